FILE: src/rcmix_pkg.sv
// ----------------------------------------------------------------------------
// rcmix_pkg
// shared types, constants and the channel check for the rc dual motor mixer
// ----------------------------------------------------------------------------
package rcmix_pkg;

  typedef enum logic [1:0] {
    MODE_PULSE_ONE = 2'd0,
    MODE_PULSE_TWO = 2'd1,
    MODE_SERIAL    = 2'd2,
    MODE_UNUSED    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_CHA_INDEX  = 3'd0,
    REG_CHB_INDEX  = 3'd1,
    REG_INDEP_MIX  = 3'd2,
    REG_DUTY_FLOOR = 3'd3,
    REG_DUTY_CEIL  = 3'd4,
    REG_HALVE_PW   = 3'd5,
    REG_DIR_POL    = 3'd6
  } reg_idx_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // reset values of the registers
  localparam logic [3:0] CHA_RST   = 4'd1;
  localparam logic [3:0] CHB_RST   = 4'd2;
  localparam logic [6:0] FLOOR_RST = 7'd0;
  localparam logic [6:0] CEIL_RST  = 7'd100;

  // channel limits
  localparam logic [15:0] PW_MIN  = 16'd800;
  localparam logic [15:0] PW_MAX  = 16'd2200;
  localparam logic [15:0] ARM_LO  = 16'd1450;
  localparam logic [15:0] ARM_HI  = 16'd1550;
  localparam logic signed [12:0] CENTRE = 13'sd1500;

  // drive shaping
  localparam logic signed [11:0] DEADBAND   = 12'sd50;
  localparam logic [10:0]        DEADBAND_U = 11'd50;
  localparam logic [10:0]        FULL_DRIVE = 11'd500;
  localparam logic [15:0]        DUTY_GAIN  = 16'd450;
  localparam logic [10:0]        DUTY_MAX   = 11'd1023;
  localparam int                 DUTY_W     = 10;
  localparam logic [DUTY_W-1:0]  DUTY_FLOOR_RST = '0;
  localparam logic [DUTY_W-1:0]  DUTY_CEIL_RST  = DUTY_W'(450 * 100 / 100);

  // serial framing
  localparam logic [7:0]  HDR_LO   = 8'h20;
  localparam logic [7:0]  HDR_HI   = 8'h40;
  localparam logic [15:0] CKS_INIT = 16'hff9f;
  localparam logic [4:0]  POS_IDLE = 5'd30;

  // divider length
  localparam int          DIV_STEPS = 16;
  localparam logic [3:0]  DIV_LAST  = 4'(DIV_STEPS - 1);

  typedef struct packed {
    logic [3:0] cha;
    logic [3:0] chb;
    logic       indep;
    logic [6:0] duty_floor;
    logic [6:0] duty_ceil;
    logic       halve;
    logic [3:0] pol;
  } cfg_t;

  typedef struct packed {
    logic               armed;
    logic signed [10:0] cmd;
  } chk_t;

  typedef struct packed {
    logic emit;
    logic locked;
  } step_stat_t;

  typedef struct packed {
    logic              fwd;
    logic              rev;
    logic [DUTY_W-1:0] duty;
  } drv_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_one;
    logic [DUTY_W-1:0] duty_two;
    logic              fwd_one;
    logic              rev_one;
    logic              fwd_two;
    logic              rev_two;
  } res_t;

  // range check and arming of one channel value
  function automatic chk_t check_channel(input logic [15:0] v, input logic armed);
    chk_t              r;
    logic signed [12:0] diff;
    r.armed = armed;
    r.cmd   = '0;
    diff    = $signed({1'b0, v[11:0]}) - CENTRE;
    if ((v < PW_MIN) || (v > PW_MAX)) begin
      r.armed = 1'b0;
    end else if (armed || ((v >= ARM_LO) && (v <= ARM_HI))) begin
      r.armed = 1'b1;
      r.cmd   = diff[10:0];
    end
    return r;
  endfunction

endpackage

FILE: src/rcmix_div.sv
// ----------------------------------------------------------------------------
// rcmix_div
// restoring divider for the two duty endpoints, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rcmix_div import rcmix_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [6:0]        floor_set,
  input  logic [6:0]        ceil_set,
  output logic              busy,
  output logic [DUTY_W-1:0] duty_floor,
  output logic [DUTY_W-1:0] duty_ceil
);

  logic              busy_r, busy_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [6:0]        span_r, span_nxt;
  logic [15:0]       qa_r, qa_nxt, qb_r, qb_nxt;
  logic [6:0]        ra_r, ra_nxt, rb_r, rb_nxt;
  logic [DUTY_W-1:0] dfl_r, dfl_nxt, dcl_r, dcl_nxt;
  logic [7:0]        trial_a, trial_b, sub_a, sub_b;
  logic              ge_a, ge_b;

  always_comb begin
    trial_a  = {ra_r, qa_r[15]};
    trial_b  = {rb_r, qb_r[15]};
    ge_a     = trial_a >= {1'b0, span_r};
    ge_b     = trial_b >= {1'b0, span_r};
    sub_a    = trial_a - {1'b0, span_r};
    sub_b    = trial_b - {1'b0, span_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    span_nxt = span_r;
    qa_nxt   = qa_r;
    qb_nxt   = qb_r;
    ra_nxt   = ra_r;
    rb_nxt   = rb_r;
    dfl_nxt  = dfl_r;
    dcl_nxt  = dcl_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      span_nxt = (ceil_set > floor_set) ? (ceil_set - floor_set) : 7'd1;
      qa_nxt   = DUTY_GAIN * {9'd0, floor_set};
      qb_nxt   = DUTY_GAIN * {9'd0, ceil_set};
      ra_nxt   = '0;
      rb_nxt   = '0;
    end else if (busy_r) begin
      qa_nxt  = {qa_r[14:0], ge_a};
      qb_nxt  = {qb_r[14:0], ge_b};
      ra_nxt  = ge_a ? sub_a[6:0] : trial_a[6:0];
      rb_nxt  = ge_b ? sub_b[6:0] : trial_b[6:0];
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == DIV_LAST) begin
        busy_nxt = 1'b0;
        // clamp, anything this large saturates further on
        dfl_nxt  = (qa_nxt > {5'd0, DUTY_MAX}) ? DUTY_MAX[DUTY_W-1:0] : qa_nxt[DUTY_W-1:0];
        dcl_nxt  = (qb_nxt > {5'd0, DUTY_MAX}) ? DUTY_MAX[DUTY_W-1:0] : qb_nxt[DUTY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      dfl_r  <= DUTY_FLOOR_RST;
      dcl_r  <= DUTY_CEIL_RST;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      dfl_r  <= dfl_nxt;
      dcl_r  <= dcl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    span_r <= span_nxt;
    qa_r   <= qa_nxt;
    qb_r   <= qb_nxt;
    ra_r   <= ra_nxt;
    rb_r   <= rb_nxt;
  end

  assign busy       = busy_r;
  assign duty_floor = dfl_r;
  assign duty_ceil  = dcl_r;

endmodule

FILE: src/rcmix_step.sv
// ----------------------------------------------------------------------------
// rcmix_step
// channel state, pulse width handling and serial frame parser
// ----------------------------------------------------------------------------
module rcmix_step import rcmix_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic [1:0]         mode,
  input  logic [15:0]        value,
  input  cfg_t               cfg,
  output logic signed [10:0] cmd_one,
  output logic signed [10:0] cmd_two,
  output logic               armed_one,
  output logic               armed_two,
  output step_stat_t         stat
);

  logic [7:0]         prev_r, prev_nxt;
  logic [4:0]         pos_r, pos_nxt;
  logic [15:0]        cks_r, cks_nxt;
  logic signed [10:0] cmd1_r, cmd1_nxt, cmd2_r, cmd2_nxt;
  logic               arm1_r, arm1_nxt, arm2_r, arm2_nxt;
  logic               locked_r, locked_nxt;
  logic               emit;
  logic [7:0]         lo, hi;
  logic [15:0]        word, pw;
  logic [4:0]         pos_inc;
  logic [3:0]         chan;
  chk_t               chk_pw, chk_sw;

  always_comb begin
    prev_nxt   = prev_r;
    pos_nxt    = pos_r;
    cks_nxt    = cks_r;
    cmd1_nxt   = cmd1_r;
    cmd2_nxt   = cmd2_r;
    arm1_nxt   = arm1_r;
    arm2_nxt   = arm2_r;
    locked_nxt = locked_r;
    emit       = 1'b0;
    lo         = prev_r;
    hi         = value[7:0];
    word       = {hi, lo};
    pos_inc    = pos_r + 5'd1;
    chan       = pos_inc[4:1];
    pw         = cfg.halve ? {1'b0, value[15:1]} : value;
    chk_pw     = check_channel(pw, (mode_t'(mode) == MODE_PULSE_ONE) ? arm1_r : arm2_r);
    chk_sw     = check_channel(word, (chan == cfg.cha) ? arm1_r : arm2_r);
    case (mode_t'(mode))
      MODE_PULSE_ONE: begin
        if (!locked_r) begin
          emit     = 1'b1;
          cmd1_nxt = chk_pw.cmd;
          arm1_nxt = chk_pw.armed;
        end
      end
      MODE_PULSE_TWO: begin
        if (!locked_r) begin
          emit     = 1'b1;
          cmd2_nxt = chk_pw.cmd;
          arm2_nxt = chk_pw.armed;
        end
      end
      MODE_SERIAL: begin
        prev_nxt = hi;
        if ((lo == HDR_LO) && (hi == HDR_HI)) begin
          // header restarts the frame wherever we are
          pos_nxt = '0;
          cks_nxt = CKS_INIT;
        end else if (pos_r < POS_IDLE) begin
          pos_nxt = pos_inc;
          if (!pos_inc[0]) begin
            if (pos_inc == POS_IDLE) begin
              if (cks_r == word) begin
                locked_nxt = 1'b1;
                emit       = 1'b1;
              end
            end else begin
              if (chan == cfg.cha) begin
                cmd1_nxt = chk_sw.cmd;
                arm1_nxt = chk_sw.armed;
              end else if (chan == cfg.chb) begin
                cmd2_nxt = chk_sw.cmd;
                arm2_nxt = chk_sw.armed;
              end
              cks_nxt = cks_r - ({8'd0, lo} + {8'd0, hi});
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      pos_r    <= POS_IDLE;
      cks_r    <= '0;
      cmd1_r   <= '0;
      cmd2_r   <= '0;
      arm1_r   <= 1'b0;
      arm2_r   <= 1'b0;
      locked_r <= 1'b0;
    end else if (go) begin
      prev_r   <= prev_nxt;
      pos_r    <= pos_nxt;
      cks_r    <= cks_nxt;
      cmd1_r   <= cmd1_nxt;
      cmd2_r   <= cmd2_nxt;
      arm1_r   <= arm1_nxt;
      arm2_r   <= arm2_nxt;
      locked_r <= locked_nxt;
    end
  end

  // results use the state as left by this item
  assign cmd_one     = cmd1_nxt;
  assign cmd_two     = cmd2_nxt;
  assign armed_one   = arm1_nxt;
  assign armed_two   = arm2_nxt;
  assign stat.emit   = emit;
  assign stat.locked = locked_r;

endmodule

FILE: src/rcmix_mix.sv
// ----------------------------------------------------------------------------
// rcmix_mix
// tank or independent mixing, deadband, duty ramp and direction flags
// ----------------------------------------------------------------------------
module rcmix_mix import rcmix_pkg::*; (
  input  logic signed [10:0] cmd_one,
  input  logic signed [10:0] cmd_two,
  input  cfg_t               cfg,
  input  logic [DUTY_W-1:0]  duty_floor,
  input  logic [DUTY_W-1:0]  duty_ceil,
  output res_t               res
);

  function automatic drv_t drive(input logic signed [11:0] m,
                                 input logic [DUTY_W-1:0] dfl,
                                 input logic [DUTY_W-1:0] dcl);
    drv_t        r;
    logic [10:0] mag;
    logic [10:0] sum;
    r.fwd = m > DEADBAND;
    r.rev = m < -DEADBAND;
    mag   = r.rev ? 11'(-m) : 11'(m);
    sum   = {1'b0, dfl} + (mag - DEADBAND_U);
    if (!r.rev && (m < DEADBAND)) begin
      r.duty = '0;
    end else if (mag > FULL_DRIVE) begin
      r.duty = dcl;
    end else begin
      r.duty = (sum > DUTY_MAX) ? DUTY_MAX[DUTY_W-1:0] : sum[DUTY_W-1:0];
    end
    return r;
  endfunction

  logic signed [11:0] m1, m2;
  drv_t               d1, d2;

  always_comb begin
    if (cfg.indep) begin
      m1 = 12'(cmd_one);
      m2 = 12'(cmd_two);
    end else begin
      m1 = 12'(cmd_one) + 12'(cmd_two);
      m2 = 12'(cmd_one) - 12'(cmd_two);
    end
    d1           = drive(m1, duty_floor, duty_ceil);
    d2           = drive(m2, duty_floor, duty_ceil);
    res.duty_one = d1.duty;
    res.duty_two = d2.duty;
    res.fwd_one  = d1.fwd ^ cfg.pol[0];
    res.rev_one  = d1.rev ^ cfg.pol[1];
    res.fwd_two  = d2.fwd ^ cfg.pol[2];
    res.rev_two  = d2.rev ^ cfg.pol[3];
  end

endmodule

FILE: src/rc_input_dual_motor_mixer.sv
// ----------------------------------------------------------------------------
// rc_input_dual_motor_mixer
// rc pulse width or serial receiver input, mixed onto two motor drives
// ----------------------------------------------------------------------------
// Takes one item per clock while the divider is idle and results are taken:
// an item is latched in an input register, passes through the compare, add
// and select logic and lands in the result register; while a finished
// result waits to be taken the input register can still take one more item.
// Pulse width items always give a result unless a good serial frame has
// locked them out; serial bytes give a result only on a frame whose checksum
// matches. Writing the duty floor or ceiling starts a 16 step divider that
// works out the two duty endpoints; the input is held off from such a write
// until the divider is done. Other register writes take effect at once.
// ----------------------------------------------------------------------------
module rc_input_dual_motor_mixer import rcmix_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_mode,
  input  logic [15:0]           in_value,
  // result items
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [9:0]            out_drive_one_duty,
  output logic [9:0]            out_drive_two_duty,
  output logic                  out_forward_one,
  output logic                  out_reverse_one,
  output logic                  out_forward_two,
  output logic                  out_reverse_two,
  output logic                  out_armed_one,
  output logic                  out_armed_two,
  // register writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  cfg_t cfg_r;
  logic div_start_r;

  // input register
  logic        in_vld_r, in_vld_nxt;
  logic [1:0]  in_mode_r;
  logic [15:0] in_value_r;

  // result register
  logic        out_vld_r, out_vld_nxt;
  res_t        out_res_r;
  logic        out_arm1_r, out_arm2_r;

  logic               in_acc, out_free, advance;
  logic               div_busy;
  logic [DUTY_W-1:0]  duty_floor, duty_ceil;
  logic signed [10:0] cmd_one, cmd_two;
  logic               armed_one, armed_two;
  step_stat_t         stat;
  res_t               res;

  // register writes, data masked to each register's width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cha        <= CHA_RST;
      cfg_r.chb        <= CHB_RST;
      cfg_r.indep      <= 1'b0;
      cfg_r.duty_floor <= FLOOR_RST;
      cfg_r.duty_ceil  <= CEIL_RST;
      cfg_r.halve      <= 1'b0;
      cfg_r.pol        <= '0;
      div_start_r      <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_CHA_INDEX:  cfg_r.cha   <= cfg_data[3:0];
          REG_CHB_INDEX:  cfg_r.chb   <= cfg_data[3:0];
          REG_INDEP_MIX:  cfg_r.indep <= cfg_data[0];
          REG_DUTY_FLOOR: begin
            cfg_r.duty_floor <= cfg_data;
            div_start_r      <= 1'b1;
          end
          REG_DUTY_CEIL: begin
            cfg_r.duty_ceil <= cfg_data;
            div_start_r     <= 1'b1;
          end
          REG_HALVE_PW:   cfg_r.halve <= cfg_data[0];
          REG_DIR_POL:    cfg_r.pol   <= cfg_data[3:0];
          default: begin
          end
        endcase
      end
    end
  end

  // duty endpoints, recomputed after a floor or ceiling write
  rcmix_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (div_start_r),
    .floor_set  (cfg_r.duty_floor),
    .ceil_set   (cfg_r.duty_ceil),
    .busy       (div_busy),
    .duty_floor (duty_floor),
    .duty_ceil  (duty_ceil)
  );

  // the stored item moves on whenever the result register can take a result
  assign out_free = !out_vld_r || out_ready;
  assign advance  = in_vld_r && out_free;
  assign in_ready = !div_busy && !div_start_r && (!in_vld_r || out_free);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_mode_r  <= in_mode;
      in_value_r <= in_value;
    end
  end

  // channel state and frame parser
  rcmix_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (advance),
    .mode      (in_mode_r),
    .value     (in_value_r),
    .cfg       (cfg_r),
    .cmd_one   (cmd_one),
    .cmd_two   (cmd_two),
    .armed_one (armed_one),
    .armed_two (armed_two),
    .stat      (stat)
  );

  // mixing and drive shaping
  rcmix_mix u_mix (
    .cmd_one    (cmd_one),
    .cmd_two    (cmd_two),
    .cfg        (cfg_r),
    .duty_floor (duty_floor),
    .duty_ceil  (duty_ceil),
    .res        (res)
  );

  // result register, loaded only by items that give a result
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance && stat.emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stat.emit) begin
      out_res_r  <= res;
      out_arm1_r <= armed_one;
      out_arm2_r <= armed_two;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_drive_one_duty = out_res_r.duty_one;
  assign out_drive_two_duty = out_res_r.duty_two;
  assign out_forward_one    = out_res_r.fwd_one;
  assign out_reverse_one    = out_res_r.rev_one;
  assign out_forward_two    = out_res_r.fwd_two;
  assign out_reverse_two    = out_res_r.rev_two;
  assign out_armed_one      = out_arm1_r;
  assign out_armed_two      = out_arm2_r;

  // no item is taken while the duty endpoints are being worked out
  a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (div_busy || div_start_r) |-> !in_ready)
    else $error("item accepted during endpoint division");

  // a floor or ceiling write always sets the divider going
  a_div_starts: assert property (@(posedge clk) disable iff (!rst_n)
    div_start_r |=> div_busy)
    else $error("divider did not start after endpoint write");

  // serial lock-out holds until reset
  a_lock_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    stat.locked |=> stat.locked)
    else $error("serial lock-out released");

  // a locked block gives no result for a pulse width item
  a_locked_pulse_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.locked && (mode_t'(in_mode_r) != MODE_SERIAL)) |-> !stat.emit)
    else $error("pulse item gave a result while locked");

  // with no inversion a motor is never driven both ways
  a_dir_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (cfg_r.pol == 4'd0)) |->
      !(out_forward_one && out_reverse_one) && !(out_forward_two && out_reverse_two))
    else $error("forward and reverse both set");

endmodule
